// ----- src/gpq_pkg.sv -----
// Shared types and constants for the grid proximity query block.
package gpq_pkg;

    // Request kinds.
    localparam logic REQ_INSERT = 1'b0;
    localparam logic REQ_QUERY  = 1'b1;

    // Configuration register indexes.
    localparam logic REG_CELL_SIZE = 1'b0;

    // Divider operand widths: numerator covers radius plus cell size minus one.
    localparam int NUM_W = 17;
    localparam int DEN_W = 16;
    localparam int CNT_W = 5;

    typedef struct packed {
        logic        req_type;
        logic [15:0] x_coord;
        logic [15:0] y_coord;
        logic [15:0] radius;
    } req_t;

    typedef struct packed {
        logic        found_close;
        logic        insert_ok;
        logic        reach_clipped;
        logic [13:0] stored_points;
    } rsp_t;

    typedef enum logic [4:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_DIV_X,
        ST_DIV_Y,
        ST_DIV_R,
        ST_WRAP_X,
        ST_WRAP_Y,
        ST_INS_RD,
        ST_INS_WR,
        ST_R2,
        ST_CELL_RD,
        ST_CELL_CHK,
        ST_PT_RD,
        ST_PT_D1,
        ST_PT_D2,
        ST_PT_D3,
        ST_NEXT_CELL,
        ST_DONE
    } state_t;

endpackage

// ----- src/grid_proximity_query_core.sv -----
// Top level of the grid proximity query block: sequencer, grid memories and APB port.
//
// Requests arrive on req/req_valid and are taken when req_stall is low. An insert
// stores a point in its grid cell; a query reports whether any stored point lies
// strictly closer than the radius. Each request gives one response on rsp/rsp_valid,
// held until a cycle with rsp_stall low takes it.
// One request is worked at a time. Bucket offsets come from one bit-serial divider;
// wrapped cell indexes are found by reciprocal multiplication. An insert takes two
// divisions; a query takes three, then reads each visited cell and each stored point
// in it, stopping at the first hit; up to (2*MAX_REACH+1)^2 cells are visited.
// A zero radius or an empty store answers after the first two divisions.
// After reset the cell fill memory is cleared, one cell per cycle over all
// GRID_SIDE*GRID_SIDE cells, and req_stall stays high during that pass.
// A finished response waits in the output register; the next request is still
// taken while the receiver stalls, and its result waits until the register frees.
// The user writes cell_size over APB at address 0 while the block is idle (unchecked).
module grid_proximity_query_core #(
    parameter int GRID_SIDE     = 32,
    parameter int CELL_CAPACITY = 8,
    parameter int MAX_REACH     = 4,
    parameter int COORD_BITS    = 16
) (
    input  logic          clk,
    input  logic          rst_n,
    input  gpq_pkg::req_t req,
    input  logic          req_valid,
    output logic          req_stall,
    output gpq_pkg::rsp_t rsp,
    output logic          rsp_valid,
    input  logic          rsp_stall,
    input  logic          psel,
    input  logic          penable,
    input  logic          pwrite,
    input  logic [2:0]    paddr,
    input  logic [31:0]   pwdata,
    output logic [31:0]   prdata,
    output logic          pready
);
    import gpq_pkg::*;

    localparam int CELL_COUNT = GRID_SIDE * GRID_SIDE;
    localparam int SLOT_COUNT = CELL_COUNT * CELL_CAPACITY;
    localparam int GW         = $clog2(GRID_SIDE);
    localparam int CELL_W     = $clog2(CELL_COUNT);
    localparam int SLOT_W     = $clog2(SLOT_COUNT);
    localparam int FILL_W     = $clog2(CELL_CAPACITY + 1);
    localparam int TOT_W      = $clog2(SLOT_COUNT + 1);
    localparam int RC_W       = 4;
    localparam logic [15:0] COORD_MASK =
        (COORD_BITS >= 16) ? 16'hFFFF : 16'((32'd1 << COORD_BITS) - 32'd1);
    // Reciprocal of GRID_SIDE, exact for every 16-bit bucket index.
    localparam int WRAP_S = 16 + $clog2(GRID_SIDE);
    localparam logic [16:0] WRAP_M =
        17'(((64'd1 << WRAP_S) + 64'(GRID_SIDE) - 64'd1) / 64'(GRID_SIDE));

    state_t state_reg, state_next;

    logic [15:0]       cell_size_reg;
    logic [15:0]       cs_eff;
    logic [CELL_W-1:0] clr_cnt_reg;
    logic [TOT_W-1:0]  total_reg;
    logic              rsp_valid_reg;
    rsp_t              rsp_reg;

    logic              type_reg;
    logic [15:0]       qx_reg, qy_reg, r_reg;
    logic [31:0]       r2_reg;
    logic [15:0]       bx_reg, by_reg;
    logic [NUM_W-1:0]  cx_reg, cx0_reg, cx_end_reg;
    logic [NUM_W-1:0]  cy_reg, cy0_reg, cy_end_reg;
    logic [GW-1:0]     wx_reg, wx0_reg, wy_reg;
    logic [15:0]       wq_x_reg, wq_y_reg;
    logic [FILL_W-1:0] k_reg, n_reg;
    logic              found_reg, ok_reg, clipped_reg;

    logic              div_start;
    logic [NUM_W-1:0]  div_num;
    logic [DEN_W-1:0]  div_den;
    logic              div_done;
    logic [NUM_W-1:0]  div_q;

    logic [15:0]       xm, ym;
    logic              reach_over;
    logic [RC_W-1:0]   rc_c;
    logic [NUM_W-1:0]  cx0_c, cy0_c;
    logic [15:0]       wsrc_x, wsrc_y;
    logic [32:0]       wprod_x, wprod_y;
    logic [15:0]       wrem_x, wrem_y;
    logic [CELL_W-1:0] cell_c;
    logic [SLOT_W-1:0] slot_rd, slot_wr;
    logic              hit;
    logic              ins_fits;
    logic              rsp_free;

    logic [FILL_W-1:0] fill_mem [CELL_COUNT];
    logic [31:0]       pt_mem [SLOT_COUNT];
    logic [FILL_W-1:0] fill_q;
    logic [31:0]       pt_q;

    // Input masking and effective cell size.
    assign xm     = req.x_coord & COORD_MASK;
    assign ym     = req.y_coord & COORD_MASK;
    assign cs_eff = (cell_size_reg == 16'd0) ? 16'd1 : cell_size_reg;

    // Reach clipping and the lower corner of the search window.
    assign reach_over = div_q > NUM_W'(MAX_REACH);
    assign rc_c  = reach_over ? RC_W'(MAX_REACH) : div_q[RC_W-1:0];
    assign cx0_c = ({1'b0, bx_reg} >= NUM_W'(rc_c)) ? ({1'b0, bx_reg} - NUM_W'(rc_c)) : '0;
    assign cy0_c = ({1'b0, by_reg} >= NUM_W'(rc_c)) ? ({1'b0, by_reg} - NUM_W'(rc_c)) : '0;

    // Wrapping onto the grid: quotient by reciprocal multiply, then the remainder.
    assign wsrc_x  = (type_reg == REQ_INSERT) ? bx_reg : cx0_reg[15:0];
    assign wsrc_y  = (type_reg == REQ_INSERT) ? by_reg : cy0_reg[15:0];
    assign wprod_x = 33'(wsrc_x) * 33'(WRAP_M);
    assign wprod_y = 33'(wsrc_y) * 33'(WRAP_M);
    assign wrem_x  = wsrc_x - 16'(wq_x_reg * GRID_SIDE);
    assign wrem_y  = wsrc_y - 16'(wq_y_reg * GRID_SIDE);

    // Memory addresses.
    assign cell_c   = CELL_W'(wy_reg * GRID_SIDE) + CELL_W'(wx_reg);
    assign slot_rd  = SLOT_W'(cell_c * CELL_CAPACITY) + SLOT_W'(k_reg);
    assign slot_wr  = SLOT_W'(cell_c * CELL_CAPACITY) + SLOT_W'(fill_q);
    assign ins_fits = fill_q < FILL_W'(CELL_CAPACITY);
    assign rsp_free = !rsp_valid_reg || !rsp_stall;

    gpq_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (div_num),
        .den   (div_den),
        .done  (div_done),
        .quo   (div_q)
    );

    gpq_dist u_dist (
        .clk       (clk),
        .point     (pt_q),
        .qx        (qx_reg),
        .qy        (qy_reg),
        .radius    (r_reg),
        .radius_sq (r2_reg),
        .hit       (hit)
    );

    // Cell fill memory: clearing pass after reset, increment on insert.
    always_ff @(posedge clk)
    begin
        if (state_reg == ST_CLEAR)
        begin
            fill_mem[clr_cnt_reg] <= '0;
        end
        else if (state_reg == ST_INS_WR && ins_fits)
        begin
            fill_mem[cell_c] <= fill_q + 1'b1;
        end
        fill_q <= fill_mem[cell_c];
    end

    // Point memory.
    always_ff @(posedge clk)
    begin
        if (state_reg == ST_INS_WR && ins_fits)
        begin
            pt_mem[slot_wr] <= {qx_reg, qy_reg};
        end
        pt_q <= pt_mem[slot_rd];
    end

    // Sequencer next state and divider launch.
    always_comb
    begin
        state_next = state_reg;
        div_start  = 1'b0;
        div_num    = '0;
        div_den    = cs_eff;
        case (state_reg)
            ST_CLEAR:
            begin
                if (clr_cnt_reg == CELL_W'(CELL_COUNT - 1))
                    state_next = ST_IDLE;
            end
            ST_IDLE:
            begin
                if (req_valid)
                begin
                    div_start  = 1'b1;
                    div_num    = NUM_W'(xm);
                    state_next = ST_DIV_X;
                end
            end
            ST_DIV_X:
            begin
                if (div_done)
                begin
                    div_start  = 1'b1;
                    div_num    = NUM_W'(qy_reg);
                    state_next = ST_DIV_Y;
                end
            end
            ST_DIV_Y:
            begin
                if (div_done)
                begin
                    if (type_reg == REQ_INSERT)
                    begin
                        state_next = ST_WRAP_X;
                    end
                    else if (r_reg == 16'd0 || total_reg == '0)
                    begin
                        state_next = ST_DONE;
                    end
                    else
                    begin
                        div_start  = 1'b1;
                        div_num    = NUM_W'(r_reg) + NUM_W'(cs_eff) - 1'b1;
                        state_next = ST_DIV_R;
                    end
                end
            end
            ST_DIV_R:
            begin
                if (div_done)
                    state_next = ST_WRAP_X;
            end
            ST_WRAP_X:    state_next = ST_WRAP_Y;
            ST_WRAP_Y:    state_next = (type_reg == REQ_INSERT) ? ST_INS_RD : ST_R2;
            ST_INS_RD:    state_next = ST_INS_WR;
            ST_INS_WR:    state_next = ST_DONE;
            ST_R2:        state_next = ST_CELL_RD;
            ST_CELL_RD:   state_next = ST_CELL_CHK;
            ST_CELL_CHK:  state_next = (fill_q == '0) ? ST_NEXT_CELL : ST_PT_RD;
            ST_PT_RD:     state_next = ST_PT_D1;
            ST_PT_D1:     state_next = ST_PT_D2;
            ST_PT_D2:     state_next = ST_PT_D3;
            ST_PT_D3:
            begin
                if (hit)
                    state_next = ST_DONE;
                else if (k_reg + 1'b1 == n_reg)
                    state_next = ST_NEXT_CELL;
                else
                    state_next = ST_PT_RD;
            end
            ST_NEXT_CELL:
            begin
                if (cx_reg == cx_end_reg && cy_reg == cy_end_reg)
                    state_next = ST_DONE;
                else
                    state_next = ST_CELL_RD;
            end
            ST_DONE:
            begin
                if (rsp_free)
                    state_next = ST_IDLE;
            end
            default:      state_next = ST_IDLE;
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clr_cnt_reg   <= '0;
            total_reg     <= '0;
            rsp_valid_reg <= 1'b0;
            cell_size_reg <= 16'd4;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == ST_CLEAR)
                clr_cnt_reg <= clr_cnt_reg + 1'b1;
            if (state_reg == ST_INS_WR && ins_fits)
                total_reg <= total_reg + 1'b1;
            if (state_reg == ST_DONE && rsp_free)
                rsp_valid_reg <= 1'b1;
            else if (!rsp_stall)
                rsp_valid_reg <= 1'b0;
            if (psel && penable && pwrite && paddr[2] == REG_CELL_SIZE)
                cell_size_reg <= pwdata[15:0];
        end
    end

    // Working registers of the current request.
    always_ff @(posedge clk)
    begin
        case (state_reg)
            ST_IDLE:
            begin
                type_reg <= req.req_type;
                qx_reg   <= xm;
                qy_reg   <= ym;
                r_reg    <= req.radius;
            end
            ST_DIV_X:
            begin
                if (div_done)
                    bx_reg <= div_q[15:0];
            end
            ST_DIV_Y:
            begin
                if (div_done)
                begin
                    by_reg      <= div_q[15:0];
                    found_reg   <= 1'b0;
                    ok_reg      <= 1'b0;
                    clipped_reg <= 1'b0;
                end
            end
            ST_DIV_R:
            begin
                if (div_done)
                begin
                    clipped_reg <= reach_over;
                    cx0_reg     <= cx0_c;
                    cx_reg      <= cx0_c;
                    cx_end_reg  <= NUM_W'(bx_reg) + NUM_W'(rc_c);
                    cy0_reg     <= cy0_c;
                    cy_reg      <= cy0_c;
                    cy_end_reg  <= NUM_W'(by_reg) + NUM_W'(rc_c);
                end
            end
            ST_WRAP_X:
            begin
                wq_x_reg <= 16'(wprod_x >> WRAP_S);
                wq_y_reg <= 16'(wprod_y >> WRAP_S);
            end
            ST_WRAP_Y:
            begin
                wx_reg  <= GW'(wrem_x);
                wx0_reg <= GW'(wrem_x);
                wy_reg  <= GW'(wrem_y);
            end
            ST_INS_WR:
            begin
                ok_reg <= ins_fits;
            end
            ST_R2:
            begin
                r2_reg <= r_reg * r_reg;
            end
            ST_CELL_CHK:
            begin
                n_reg <= fill_q;
                k_reg <= '0;
            end
            ST_PT_D3:
            begin
                if (hit)
                    found_reg <= 1'b1;
                k_reg <= k_reg + 1'b1;
            end
            ST_NEXT_CELL:
            begin
                // Walk the window row by row with wrapped cell indexes.
                if (cx_reg == cx_end_reg)
                begin
                    cx_reg <= cx0_reg;
                    wx_reg <= wx0_reg;
                    cy_reg <= cy_reg + 1'b1;
                    wy_reg <= (wy_reg == GW'(GRID_SIDE - 1)) ? '0 : wy_reg + 1'b1;
                end
                else
                begin
                    cx_reg <= cx_reg + 1'b1;
                    wx_reg <= (wx_reg == GW'(GRID_SIDE - 1)) ? '0 : wx_reg + 1'b1;
                end
            end
            ST_DONE:
            begin
                if (rsp_free)
                begin
                    rsp_reg.found_close   <= found_reg;
                    rsp_reg.insert_ok     <= ok_reg;
                    rsp_reg.reach_clipped <= clipped_reg;
                    rsp_reg.stored_points <= 14'(total_reg);
                end
            end
            default:
            begin
            end
        endcase
    end

    // Ports.
    assign req_stall = (state_reg != ST_IDLE);
    assign rsp       = rsp_reg;
    assign rsp_valid = rsp_valid_reg;
    assign prdata    = (paddr[2] == REG_CELL_SIZE) ? {16'd0, cell_size_reg} : 32'd0;
    assign pready    = 1'b1;

endmodule

// ----- src/gpq_div.sv -----
// Bit-serial restoring divider, one quotient bit per cycle.
module gpq_div (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    input  logic [gpq_pkg::NUM_W-1:0] num,
    input  logic [gpq_pkg::DEN_W-1:0] den,
    output logic                      done,
    output logic [gpq_pkg::NUM_W-1:0] quo
);
    import gpq_pkg::*;

    logic             busy_reg;
    logic             done_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [NUM_W-1:0] quo_reg;
    logic [DEN_W:0]   rem_reg;
    logic [DEN_W-1:0] den_reg;
    logic [DEN_W:0]   shifted;
    logic             ge;

    // One trial subtraction per cycle.
    assign shifted = {rem_reg[DEN_W-1:0], quo_reg[NUM_W-1]};
    assign ge      = shifted >= {1'b0, den_reg};

    // Control.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(NUM_W - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Datapath: numerator shifts out as quotient bits shift in.
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg <= num;
            rem_reg <= '0;
            den_reg <= den;
        end
        else if (busy_reg)
        begin
            quo_reg <= {quo_reg[NUM_W-2:0], ge};
            rem_reg <= ge ? (shifted - {1'b0, den_reg}) : shifted;
        end
    end

    assign done = done_reg;
    assign quo  = quo_reg;

endmodule

// ----- src/gpq_dist.sv -----
// Pipelined squared-distance check of one stored point against the query.
module gpq_dist (
    input  logic        clk,
    input  logic [31:0] point,
    input  logic [15:0] qx,
    input  logic [15:0] qy,
    input  logic [15:0] radius,
    input  logic [31:0] radius_sq,
    output logic        hit
);
    logic [15:0] px;
    logic [15:0] py;
    logic [15:0] dx_reg;
    logic [15:0] dy_reg;
    logic        near_reg;
    logic [31:0] dx2_reg;
    logic [31:0] dy2_reg;
    logic        near2_reg;

    assign px = point[31:16];
    assign py = point[15:0];

    // First stage: absolute differences and the per-axis bound.
    always_ff @(posedge clk)
    begin
        dx_reg   <= (px > qx) ? (px - qx) : (qx - px);
        dy_reg   <= (py > qy) ? (py - qy) : (qy - py);
        near_reg <= ((px > qx) ? (px - qx) : (qx - px)) < radius &&
                    ((py > qy) ? (py - qy) : (qy - py)) < radius;
    end

    // Second stage: squares.
    always_ff @(posedge clk)
    begin
        dx2_reg   <= dx_reg * dx_reg;
        dy2_reg   <= dy_reg * dy_reg;
        near2_reg <= near_reg;
    end

    assign hit = near2_reg &&
                 (({1'b0, dx2_reg} + {1'b0, dy2_reg}) < {1'b0, radius_sq});

endmodule

// ----- tb/gpq_checker.sv -----
// Checker for the grid proximity query block: spatial grid predictor and response comparison.
module gpq_checker #(
    parameter int GRID_SIDE     = 32,
    parameter int CELL_CAPACITY = 8,
    parameter int MAX_REACH     = 4
) (
    input  logic          clk,
    input  logic          rst_n,
    input  gpq_pkg::req_t req,
    input  logic          req_valid,
    input  logic          req_stall,
    input  gpq_pkg::rsp_t rsp,
    input  logic          rsp_valid,
    input  logic          rsp_stall,
    input  logic          psel,
    input  logic          penable,
    input  logic          pwrite,
    input  logic [2:0]    paddr,
    input  logic [31:0]   pwdata,
    output int            fail_count,
    output int            pending_count,
    output int            queries_seen,
    output int            hits_seen,
    output int            rejects_seen
);
    import gpq_pkg::*;

    localparam int CELLS = GRID_SIDE * GRID_SIDE;

    // Model of the grid contents.
    logic [15:0] grid_cell_size;
    int          grid_fill [CELLS];
    logic [31:0] grid_points [CELLS * CELL_CAPACITY];
    logic [13:0] grid_total;
    rsp_t        rsp_expected [$];

    // Looks for a stored point in one cell strictly inside the radius.
    function automatic bit cell_near(int c, int qx, int qy, int r);
        longint dx;
        longint dy;
        for (int k = 0; k < grid_fill[c]; k++)
        begin
            dx = longint'(grid_points[c * CELL_CAPACITY + k][31:16]) - qx;
            dy = longint'(grid_points[c * CELL_CAPACITY + k][15:0]) - qy;
            if (dx * dx + dy * dy < longint'(r) * r)
                return 1'b1;
        end
        return 1'b0;
    endfunction

    // Applies one request to the model grid and returns the response it gives.
    function automatic rsp_t grid_apply(req_t q);
        rsp_t o;
        int   cs;
        int   bx;
        int   by;
        int   c;
        int   reach;
        o = '0;
        cs = (grid_cell_size == 0) ? 1 : grid_cell_size;
        bx = q.x_coord / cs;
        by = q.y_coord / cs;
        if (q.req_type == REQ_INSERT)
        begin
            c = (by % GRID_SIDE) * GRID_SIDE + (bx % GRID_SIDE);
            if (grid_fill[c] < CELL_CAPACITY)
            begin
                grid_points[c * CELL_CAPACITY + grid_fill[c]] = {q.x_coord, q.y_coord};
                grid_fill[c]++;
                grid_total++;
                o.insert_ok = 1'b1;
            end
        end
        else if (q.radius != 0 && grid_total != 0)
        begin
            reach = (int'(q.radius) + cs - 1) / cs;
            if (reach > MAX_REACH)
            begin
                reach = MAX_REACH;
                o.reach_clipped = 1'b1;
            end
            for (int cy = by - reach; cy <= by + reach; cy++)
                for (int cx = bx - reach; cx <= bx + reach; cx++)
                    if (cy >= 0 && cx >= 0 && !o.found_close)
                        o.found_close = cell_near((cy % GRID_SIDE) * GRID_SIDE
                            + (cx % GRID_SIDE), q.x_coord, q.y_coord, q.radius);
        end
        o.stored_points = grid_total;
        return o;
    endfunction

    assign pending_count = rsp_expected.size();

    // Track register writes, accepted requests and responses.
    always @(posedge clk or negedge rst_n)
    begin
        rsp_t want;
        if (!rst_n)
        begin
            grid_cell_size <= 16'd4;
            grid_total = '0;
            foreach (grid_fill[i]) grid_fill[i] = 0;
            rsp_expected.delete();
            fail_count <= 0;
            queries_seen <= 0;
            hits_seen <= 0;
            rejects_seen <= 0;
        end
        else
        begin
            if (psel && penable && pwrite && paddr == 3'(4 * REG_CELL_SIZE))
                grid_cell_size <= pwdata[15:0];
            if (req_valid && !req_stall)
            begin
                want = grid_apply(req);
                rsp_expected = {rsp_expected, want};
                if (req.req_type == REQ_QUERY)
                    queries_seen <= queries_seen + 1;
                if (want.found_close)
                    hits_seen <= hits_seen + 1;
                if (req.req_type == REQ_INSERT && !want.insert_ok)
                    rejects_seen <= rejects_seen + 1;
            end
            if (rsp_valid && !rsp_stall)
            begin
                if (rsp_expected.size() == 0)
                begin
                    $display("%0t: response with none expected, actual %p", $time, rsp);
                    fail_count <= fail_count + 1;
                end
                else
                begin
                    want = rsp_expected.pop_front();
                    if (rsp !== want)
                    begin
                        $display("%0t: response mismatch, expected %p, actual %p",
                                 $time, want, rsp);
                        fail_count <= fail_count + 1;
                    end
                end
            end
        end
    end
endmodule

// ----- tb/testbench.sv -----
// Top of the grid proximity query testbench: stimulus, configuration and verdict.
module testbench;
    import gpq_pkg::*;

    localparam longint CYCLE_LIMIT = 64'd20000000;

    logic        clk;
    logic        rst_n;
    req_t        req;
    logic        req_valid;
    logic        req_stall;
    rsp_t        rsp;
    logic        rsp_valid;
    logic        rsp_stall;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;
    int          fail_count;
    int          pending_count;
    int          queries_seen;
    int          hits_seen;
    int          rejects_seen;
    longint      cycle_count;
    int          requests_sent;
    logic [15:0] anchor_x;
    logic [15:0] anchor_y;

    grid_proximity_query_core dut (.*);

    gpq_checker checker_i (.*);

    // Clock with an 8 unit period.
    initial clk = 1'b0;
    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // Cycle counter with timeout.
    initial cycle_count = 0;
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("[grid_proximity_query_core] ERROR");
            $finish;
        end
    end

    // Receiver stalls: mostly short, sometimes long, sometimes none.
    initial
    begin
        int n;
        rsp_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            n = $urandom_range(0, 99);
            if (n < 40)
                rsp_stall <= 1'b0;
            else if (n < 95)
                rsp_stall <= 1'b1;
            else
            begin
                rsp_stall <= 1'b1;
                repeat ($urandom_range(20, 200)) @(negedge clk);
                rsp_stall <= 1'b0;
            end
        end
    end

    // Random idle cycles between requests.
    task automatic sender_gap();
        int n;
        n = $urandom_range(0, 99);
        if (n < 30)
            return;
        else if (n < 95)
            repeat ($urandom_range(1, 3)) @(negedge clk);
        else
            repeat ($urandom_range(20, 150)) @(negedge clk);
    endtask

    // Presents one request and holds it until taken.
    task automatic send_request(logic kind, logic [15:0] x, logic [15:0] y, logic [15:0] r);
        req_valid <= 1'b1;
        req <= '{req_type: kind, x_coord: x, y_coord: y, radius: r};
        @(posedge clk);
        while (req_stall) @(posedge clk);
        @(negedge clk);
        req_valid <= 1'b0;
        requests_sent++;
        sender_gap();
    endtask

    // Waits for every response, then lets the block settle.
    task automatic drain();
        while (pending_count != 0) @(negedge clk);
        repeat (20) @(negedge clk);
    endtask

    // APB write of the cell size; block must be idle.
    task automatic write_cell_size(logic [15:0] v);
        psel <= 1'b1;
        pwrite <= 1'b1;
        penable <= 1'b0;
        paddr <= 3'(4 * REG_CELL_SIZE);
        pwdata <= {16'h0, v};
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready) @(posedge clk);
        @(negedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    // Clusters of inserts and queries around a moving anchor, plus scattered noise.
    task automatic random_phase(int count, int coord_hi, int radius_hi);
        int          k;
        logic [15:0] x;
        logic [15:0] y;
        for (k = 0; k < count; k++)
        begin
            if ($urandom_range(0, 9) == 0)
            begin
                anchor_x = 16'($urandom_range(0, coord_hi));
                anchor_y = 16'($urandom_range(0, coord_hi));
            end
            x = 16'(anchor_x + $urandom_range(0, 64) - 32);
            y = 16'(anchor_y + $urandom_range(0, 64) - 32);
            if ($urandom_range(0, 7) == 0)
                send_request(1'($urandom_range(0, 1)), 16'($urandom), 16'($urandom),
                             16'($urandom));
            else if ($urandom_range(0, 2) == 0)
                send_request(REQ_INSERT, x, y, 16'($urandom));
            else
                send_request(REQ_QUERY, x, y, 16'($urandom_range(0, radius_hi)));
        end
    endtask

    initial
    begin
        rst_n = 1'b0;
        req = '0;
        req_valid = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        requests_sent = 0;
        anchor_x = 16'd100;
        anchor_y = 16'd100;
        repeat (2) @(negedge clk);
        rst_n = 1'b1;

        // Directed: empty store, zero radius, extremes, full cell, clipped reach.
        send_request(REQ_QUERY, 16'd10, 16'd10, 16'd50);
        send_request(REQ_INSERT, 16'd0, 16'd0, 16'hFFFF);
        send_request(REQ_QUERY, 16'd0, 16'd0, 16'd0);
        send_request(REQ_QUERY, 16'd1, 16'd0, 16'd1);
        send_request(REQ_QUERY, 16'd1, 16'd0, 16'd2);
        send_request(REQ_INSERT, 16'hFFFF, 16'hFFFF, 16'd0);
        send_request(REQ_QUERY, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        for (int i = 0; i < 9; i++)
            send_request(REQ_INSERT, 16'd40, 16'd41, 16'd0);
        send_request(REQ_INSERT, 16'd168, 16'd41, 16'd0);
        send_request(REQ_QUERY, 16'd44, 16'd41, 16'd5);
        send_request(REQ_QUERY, 16'd3, 16'd4, 16'd5);
        send_request(REQ_QUERY, 16'd3, 16'd4, 16'd6);
        send_request(REQ_QUERY, 16'd300, 16'd300, 16'd17);
        drain();

        // Random phases over several cell sizes, extremes included.
        write_cell_size(16'd0);
        random_phase(150, 400, 12);
        drain();
        write_cell_size(16'd1);
        random_phase(150, 600, 8);
        drain();
        write_cell_size(16'd16);
        random_phase(300, 2000, 120);
        drain();
        write_cell_size(16'hFFFF);
        random_phase(150, 65535, 65535);
        drain();
        write_cell_size(16'd7);
        random_phase(250, 1500, 60);
        drain();
        write_cell_size(16'd4);
        random_phase(280, 800, 40);
        drain();

        $display("Sent %0d requests, %0d queries with %0d hits, %0d inserts rejected.",
                 requests_sent, queries_seen, hits_seen, rejects_seen);
        if (fail_count == 0)
            $display("[grid_proximity_query_core] OK");
        else
            $display("[grid_proximity_query_core] ERROR");
        $finish;
    end
endmodule

// ----- grid_proximity_query_core.f -----
src/gpq_pkg.sv
src/gpq_div.sv
src/gpq_dist.sv
src/grid_proximity_query_core.sv
tb/gpq_checker.sv
tb/testbench.sv
